>>> sv/asp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_pkg: shared types and constants for the static box push-out block
// Command codes, sequencer states, table geometry and the control bundle
// that steers the push unit.
// ----------------------------------------------------------------------------
package asp_pkg;

	localparam int MAX_BOXES      = 128;
	localparam int RESOLVE_PASSES = 2;
	localparam int IDX_W          = $clog2(MAX_BOXES);
	localparam int CNT_W          = 8;
	localparam int PASS_W         = (RESOLVE_PASSES > 1) ? $clog2(RESOLVE_PASSES) : 1;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_APPEND  = 2'd1,
		CMD_RESOLVE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EV1,
		ST_EV2,
		ST_APPLY
	} state_t;

	// one static box as held in the table
	typedef struct packed {
		logic [31:0] cx;
		logic [31:0] cy;
		logic [29:0] hx;
		logic [29:0] hy;
	} box_t;

	// stage loads for the push unit
	typedef struct packed {
		logic ld1;
		logic ld2;
	} push_ctl_t;

endpackage

>>> sv/asp_push_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_push_unit: penetration and push arithmetic for one static box
// Reused for every table entry of every pass: offsets and extent sums,
// then penetrations, then overlap test and saturated push of the center.
// ----------------------------------------------------------------------------
module asp_push_unit (
	input  logic                     clk,
	input  asp_pkg::push_ctl_t       ctl,
	input  asp_pkg::box_t            entry,
	input  logic signed [31:0]       cx,
	input  logic signed [31:0]       cy,
	input  logic        [29:0]       hx,
	input  logic        [29:0]       hy,
	output logic                     hit,
	output logic                     along_x,
	output logic signed [31:0]       cx_push,
	output logic signed [31:0]       cy_push
);
	import asp_pkg::*;

	logic signed [32:0] dx_s1, dy_s1;
	logic        [30:0] hsx_s1, hsy_s1;
	logic signed [33:0] px_s2, py_s2;
	logic               dxneg_s2, dyneg_s2;
	logic signed [33:0] dx_w, dy_w, hsx_w, hsy_w;
	logic signed [33:0] push_x, push_y;
	logic signed [34:0] sum_x, sum_y;

	// stage 1: center offsets and extent sums
	always_ff @(posedge clk) begin
		if (ctl.ld1) begin
			dx_s1  <= $signed({entry.cx[31], entry.cx}) - $signed({cx[31], cx});
			dy_s1  <= $signed({entry.cy[31], entry.cy}) - $signed({cy[31], cy});
			hsx_s1 <= {1'b0, hx} + {1'b0, entry.hx};
			hsy_s1 <= {1'b0, hy} + {1'b0, entry.hy};
		end
	end

	assign dx_w  = {dx_s1[32], dx_s1};
	assign dy_w  = {dy_s1[32], dy_s1};
	assign hsx_w = $signed({3'b000, hsx_s1});
	assign hsy_w = $signed({3'b000, hsy_s1});

	// stage 2: penetration = extent sum - |offset|
	always_ff @(posedge clk) begin
		if (ctl.ld2) begin
			px_s2    <= dx_s1[32] ? (hsx_w + dx_w) : (hsx_w - dx_w);
			py_s2    <= dy_s1[32] ? (hsy_w + dy_w) : (hsy_w - dy_w);
			dxneg_s2 <= dx_s1[32];
			dyneg_s2 <= dy_s1[32];
		end
	end

	// stage 3: overlap, axis choice, saturated push
	assign hit     = (px_s2 > 34'sd0) && (py_s2 > 34'sd0);
	assign along_x = px_s2 < py_s2;
	assign push_x  = dxneg_s2 ? px_s2 : -px_s2;
	assign push_y  = dyneg_s2 ? py_s2 : -py_s2;
	assign sum_x   = $signed({{3{cx[31]}}, cx}) + $signed({push_x[33], push_x});
	assign sum_y   = $signed({{3{cy[31]}}, cy}) + $signed({push_y[33], push_y});

	always_comb begin
		if (sum_x[34:31] == 4'b0000 || sum_x[34:31] == 4'b1111)
			cx_push = sum_x[31:0];
		else
			cx_push = sum_x[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		if (sum_y[34:31] == 4'b0000 || sum_y[34:31] == 4'b1111)
			cy_push = sum_y[31:0];
		else
			cy_push = sum_y[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	end

endmodule

>>> sv/aabb_static_push_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_static_push_out: static box table with minimum-translation push-out
// Holds up to 128 static boxes and resolves one moving box against them.
// ----------------------------------------------------------------------------
//
//  channel   handshake           beat contents
//  -------   ---------           -------------
//  command   start / busy        command, center_x/y, half_x/y, vel_x/y
//  result    done (strobe)       new_center_x/y, new_vel_x/y, any_contact,
//                                status, box_count
//
// Clear, append and an unused command code answer without a walk: done pulses
// on the cycle after the beat and busy stays low.
// Resolve holds busy while it walks the stored boxes in one or two passes;
// done pulses in the first cycle with busy low. An empty table answers like
// clear, on the cycle after the beat. Each entry steps through the push unit
// stages (offset, penetration, apply) chained on the updated center.
// Reset clears the box count and the sequencer; table contents are not
// cleared, and only entries below the count are ever read.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module aabb_static_push_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic [29:0]        half_x,
	input  logic [29:0]        half_y,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	output logic               done,
	output logic signed [31:0] new_center_x,
	output logic signed [31:0] new_center_y,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic               any_contact,
	output logic               status,
	output logic [7:0]         box_count
);
	import asp_pkg::*;

	state_t              state_q, state_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic [PASS_W-1:0]   pass_q;
	logic [CNT_W-1:0]    count_q;
	logic                resolved_q;
	logic                done_q;
	push_ctl_t           ctl;

	logic                accept;
	logic                go_resolve;
	logic                last_entry;
	logic                walk_end;
	logic                table_full;

	// working registers; they double as the result beat
	logic signed [31:0]  cx_q, cy_q, vx_q, vy_q;
	logic        [29:0]  hx_q, hy_q;
	logic                contact_q, status_q;

	box_t                mem_q [MAX_BOXES];
	box_t                rd_q;

	logic                hit, along_x;
	logic signed [31:0]  cx_push, cy_push;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign table_full = (count_q == CNT_W'(MAX_BOXES));
	assign go_resolve = accept && (command == CMD_RESOLVE) && (count_q != '0);
	assign last_entry = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

	// sequencer: walk entries, three steps each, up to RESOLVE_PASSES passes
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		ctl      = '0;
		walk_end = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idx_d = '0;
				if (go_resolve)
					state_d = ST_EV1;
			end
			ST_EV1: begin
				ctl.ld1 = 1'b1;
				state_d = ST_EV2;
			end
			ST_EV2: begin
				ctl.ld2 = 1'b1;
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				state_d = ST_EV1;
				if (last_entry) begin
					idx_d = '0;
					// stop after a quiet pass or after the last pass
					if (!(resolved_q || hit) || pass_q == PASS_W'(RESOLVE_PASSES - 1)) begin
						state_d  = ST_IDLE;
						walk_end = 1'b1;
					end
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			pass_q     <= '0;
			resolved_q <= 1'b0;
			count_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			idx_q  <= idx_d;
			done_q <= (accept && !go_resolve) || walk_end;
			if (accept) begin
				pass_q     <= '0;
				resolved_q <= 1'b0;
				if (command == CMD_CLEAR)
					count_q <= '0;
				else if (command == CMD_APPEND && !table_full)
					count_q <= count_q + CNT_W'(1);
			end else if (state_q == ST_APPLY) begin
				if (last_entry) begin
					// advance to next pass and forget this pass's hits
					pass_q     <= pass_q + PASS_W'(1);
					resolved_q <= 1'b0;
				end else if (hit) begin
					resolved_q <= 1'b1;
				end
			end
		end
	end

	// payload: load on the beat, update on each resolved overlap
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q      <= center_x;
			cy_q      <= center_y;
			vx_q      <= vel_x;
			vy_q      <= vel_y;
			hx_q      <= half_x;
			hy_q      <= half_y;
			contact_q <= 1'b0;
			status_q  <= (command == CMD_APPEND) && table_full;
		end else if (state_q == ST_APPLY && hit) begin
			contact_q <= 1'b1;
			if (along_x) begin
				cx_q <= cx_push;
				vx_q <= '0;
			end else begin
				// ties go to Y
				cy_q <= cy_push;
				vy_q <= '0;
			end
		end
	end

	// box table: one write port for append, registered read that tracks idx
	always_ff @(posedge clk) begin
		if (accept && command == CMD_APPEND && !table_full)
			mem_q[count_q[IDX_W-1:0]] <= '{cx: center_x, cy: center_y,
				hx: half_x, hy: half_y};
		rd_q <= mem_q[idx_d];
	end

	asp_push_unit u_push (
		.clk     (clk),
		.ctl     (ctl),
		.entry   (rd_q),
		.cx      (cx_q),
		.cy      (cy_q),
		.hx      (hx_q),
		.hy      (hy_q),
		.hit     (hit),
		.along_x (along_x),
		.cx_push (cx_push),
		.cy_push (cy_push)
	);

	assign done         = done_q;
	assign new_center_x = cx_q;
	assign new_center_y = cy_q;
	assign new_vel_x    = vx_q;
	assign new_vel_y    = vy_q;
	assign any_contact  = contact_q;
	assign status       = status_q;
	assign box_count    = count_q;

endmodule

>>> sv/asp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_checker: port-level checks for the static box push-out block
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module asp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         command,
	input logic               done,
	input logic signed [31:0] new_vel_x,
	input logic signed [31:0] new_vel_y,
	input logic               any_contact,
	input logic               status,
	input logic [7:0]         box_count
);
	import asp_pkg::*;

	// a result never shows while a resolve is still walking
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	// only a resolve beat starts a walk
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && $past(command) == CMD_RESOLVE)
		else $error("busy rose without a resolve beat");

	// a clear answers next cycle with an empty table
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_CLEAR |=> done && box_count == 8'd0)
		else $error("clear did not empty the table");

	// a dropped append only happens on a full table
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> box_count == CNT_W'(MAX_BOXES))
		else $error("append dropped below capacity");

	// a resolved contact zeroes at least one velocity component
	a_contact_vel: assert property (@(posedge clk) disable iff (!arst_n)
		done && any_contact |-> new_vel_x == 32'sd0 || new_vel_y == 32'sd0)
		else $error("contact without a zeroed velocity");

endmodule

bind aabb_static_push_out asp_checker u_asp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.command     (command),
	.done        (done),
	.new_vel_x   (new_vel_x),
	.new_vel_y   (new_vel_y),
	.any_contact (any_contact),
	.status      (status),
	.box_count   (box_count)
);

>>> sim/aabb_push_out_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_push_out_checker: result predictor and scoreboard for the push-out block
// Keeps its own copy of the static box table, predicts one result for every
// accepted command beat and compares each done beat with the oldest prediction.
// ----------------------------------------------------------------------------
module aabb_push_out_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         command,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic [29:0]        half_x,
	input  logic [29:0]        half_y,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic               done,
	input  logic signed [31:0] new_center_x,
	input  logic signed [31:0] new_center_y,
	input  logic signed [31:0] new_vel_x,
	input  logic signed [31:0] new_vel_y,
	input  logic               any_contact,
	input  logic               status,
	input  logic [7:0]         box_count,
	output int                 mismatches,
	output int                 outstanding
);
	import asp_pkg::*;

	typedef struct packed {
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] vx;
		logic [31:0] vy;
		logic        contact;
		logic        dropped;
		logic [7:0]  boxes;
	} pose_t;

	int     tbl_cx [MAX_BOXES];
	int     tbl_cy [MAX_BOXES];
	longint tbl_hx [MAX_BOXES];
	longint tbl_hy [MAX_BOXES];
	int     boxes_held;
	pose_t  predicted_poses [$];
	pose_t  want;

	function automatic longint clamp_s32(input longint v);
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		return v;
	endfunction

	// Walk the table like the block does: each overlap moves the center before
	// the next box is tested; a sweep with no overlap ends the walk.
	task automatic predict_pose(input logic [1:0] cmd, input logic signed [31:0] cx,
			input logic signed [31:0] cy, input logic [29:0] hx, input logic [29:0] hy,
			input logic signed [31:0] vx, input logic signed [31:0] vy, output pose_t r);
		longint mx, my, mvx, mvy, mhx, mhy, dx, dy, px, py;
		logic   hit, touched, dropped;
		int     sweep, i;
		mx      = longint'(cx);
		my      = longint'(cy);
		mvx     = longint'(vx);
		mvy     = longint'(vy);
		mhx     = longint'(hx);
		mhy     = longint'(hy);
		touched = 1'b0;
		dropped = 1'b0;
		case (cmd)
			CMD_CLEAR: boxes_held = 0;
			CMD_APPEND: begin
				if (boxes_held < MAX_BOXES) begin
					tbl_cx[boxes_held] = cx;
					tbl_cy[boxes_held] = cy;
					tbl_hx[boxes_held] = mhx;
					tbl_hy[boxes_held] = mhy;
					boxes_held++;
				end else begin
					dropped = 1'b1;
				end
			end
			CMD_RESOLVE: begin
				for (sweep = 0; sweep < RESOLVE_PASSES; sweep++) begin
					hit = 1'b0;
					for (i = 0; i < boxes_held; i++) begin
						dx = longint'(tbl_cx[i]) - mx;
						dy = longint'(tbl_cy[i]) - my;
						px = mhx + tbl_hx[i] - ((dx < 0) ? -dx : dx);
						if (px <= 0)
							continue;
						py = mhy + tbl_hy[i] - ((dy < 0) ? -dy : dy);
						if (py <= 0)
							continue;
						// shallower axis wins, a tie goes to Y
						if (px < py) begin
							mx  = clamp_s32(mx + ((dx < 0) ? px : -px));
							mvx = 0;
						end else begin
							my  = clamp_s32(my + ((dy < 0) ? py : -py));
							mvy = 0;
						end
						hit     = 1'b1;
						touched = 1'b1;
					end
					if (!hit)
						break;
				end
			end
			default: ;
		endcase
		r.cx      = mx[31:0];
		r.cy      = my[31:0];
		r.vx      = mvx[31:0];
		r.vy      = mvy[31:0];
		r.contact = touched;
		r.dropped = dropped;
		r.boxes   = boxes_held[7:0];
	endtask

	task automatic check_field(input string name, input logic [31:0] expected_val,
			input logic [31:0] actual_val);
		if (actual_val !== expected_val) begin
			$display("%0t: %s expected %h got %h", $time, name, expected_val, actual_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boxes_held  = 0;
			mismatches  = 0;
			outstanding = 0;
			predicted_poses.delete();
		end else begin
			// compare before queuing the beat taken at this same edge
			if (done) begin
				if (predicted_poses.size() == 0) begin
					$display("%0t: result beat with no command outstanding", $time);
					mismatches++;
				end else begin
					want = predicted_poses.pop_front();
					check_field("new_center_x", want.cx, new_center_x);
					check_field("new_center_y", want.cy, new_center_y);
					check_field("new_vel_x", want.vx, new_vel_x);
					check_field("new_vel_y", want.vy, new_vel_y);
					check_field("any_contact", 32'(want.contact), 32'(any_contact));
					check_field("status", 32'(want.dropped), 32'(status));
					check_field("box_count", 32'(want.boxes), 32'(box_count));
				end
			end
			if (start && !busy) begin
				predict_pose(command, center_x, center_y, half_x, half_y, vel_x, vel_y, want);
				predicted_poses = {predicted_poses, want};
			end
			outstanding = predicted_poses.size();
		end
	end

endmodule

>>> sim/aabb_static_push_out_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_static_push_out_tb: command stimulus and verdict for the push-out block
// Drives clear, append and resolve beats in bursts with random gaps: first a
// directed set for push direction, ties, touching edges and saturation, then
// random scenes of clustered boxes with moving boxes dropped onto them.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module aabb_static_push_out_tb;
	import asp_pkg::*;

	// command code the block ignores
	localparam logic [1:0]         CMD_UNUSED   = 2'd3;
	localparam int                 RANDOM_BEATS = 2000;
	// longest resolve (full table, every sweep) with plenty of margin
	localparam int                 DRAIN_LIMIT  = 4 * 3 * MAX_BOXES * RESOLVE_PASSES;
	localparam int                 TAIL_CYCLES  = 16;
	localparam logic signed [31:0] Q_ONE        = 32'sh0001_0000;
	localparam logic signed [31:0] Q_HALF       = 32'sh0000_8000;
	localparam logic signed [31:0] Q_QTR        = 32'sh0000_4000;
	localparam logic [29:0]        H_ONE        = 30'h0001_0000;
	localparam logic [29:0]        H_WIDE       = 30'h1000_0000;
	localparam logic [29:0]        H_MAX        = 30'h3FFF_FFFF;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         command;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic [29:0]        half_x;
	logic [29:0]        half_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic               done;
	logic signed [31:0] new_center_x;
	logic signed [31:0] new_center_y;
	logic signed [31:0] new_vel_x;
	logic signed [31:0] new_vel_y;
	logic               any_contact;
	logic               status;
	logic [7:0]         box_count;
	int                 mismatches;
	int                 outstanding;

	// stimulus bookkeeping: where the boxes of the current scene sit
	logic signed [31:0] scene_cx [MAX_BOXES];
	logic signed [31:0] scene_cy [MAX_BOXES];
	int                 scene_n    = 0;
	int                 beats_sent = 0;
	int                 burst_left = 8;
	int                 drain;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	aabb_static_push_out u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.center_x     (center_x),
		.center_y     (center_y),
		.half_x       (half_x),
		.half_y       (half_y),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.done         (done),
		.new_center_x (new_center_x),
		.new_center_y (new_center_y),
		.new_vel_x    (new_vel_x),
		.new_vel_y    (new_vel_y),
		.any_contact  (any_contact),
		.status       (status),
		.box_count    (box_count)
	);

	aabb_push_out_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.center_x     (center_x),
		.center_y     (center_y),
		.half_x       (half_x),
		.half_y       (half_y),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.done         (done),
		.new_center_x (new_center_x),
		.new_center_y (new_center_y),
		.new_vel_x    (new_vel_x),
		.new_vel_y    (new_vel_y),
		.any_contact  (any_contact),
		.status       (status),
		.box_count    (box_count),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Present one command beat and hold it until the block takes it. Called at
	// a rising edge; returns at the edge that accepted the beat, or after the
	// idle gap that closes a burst. busy read right after the edge is the value
	// the block had when it sampled start.
	task automatic issue(input logic [1:0] cmd, input logic signed [31:0] cx,
			input logic signed [31:0] cy, input logic [29:0] hx, input logic [29:0] hy,
			input logic signed [31:0] vx, input logic signed [31:0] vy);
		command  <= cmd;
		center_x <= cx;
		center_y <= cy;
		half_x   <= hx;
		half_y   <= hy;
		vel_x    <= vx;
		vel_y    <= vy;
		start    <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		// ignored codes do not count toward the beat budget
		if (cmd != CMD_UNUSED)
			beats_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			// drop start for a gap; it may land while a resolve is still walking
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			// mostly short bursts, now and then a long stretch with no idling
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 12);
		end
	endtask

	// scene origin: mostly the middle, sometimes near either end of the range
	function automatic logic signed [31:0] pick_base();
		case ($urandom_range(0, 7))
			0:       return 32'sh7FF6_0000;
			1:       return -32'sh7FF6_0000;
			2:       return $urandom;
			default: return '0;
		endcase
	endfunction

	// quarter-unit grid so that ties and touching edges come up often
	function automatic logic signed [31:0] jitter(input int span);
		int q;
		q = $urandom_range(0, 2 * span);
		return (q - span) * Q_QTR;
	endfunction

	function automatic logic [29:0] half_step();
		logic [29:0] h;
		h = 30'($urandom_range(0, 16));
		return h << 14;
	endfunction

	// One scene: clear (usually), a cluster of static boxes, then moving boxes
	// placed near stored ones. A fill scene pushes past a full table.
	task automatic run_scene(input bit fill);
		logic signed [31:0] bx, by, cx, cy;
		logic [29:0]        hx, hy;
		int                 n_boxes, n_moves, k, j;
		bx = pick_base();
		by = pick_base();
		if (fill || $urandom_range(0, 9) != 0) begin
			issue(CMD_CLEAR, $urandom, $urandom, 30'($urandom), 30'($urandom),
				$urandom, $urandom);
			scene_n = 0;
		end
		if (fill)
			n_boxes = MAX_BOXES + 2;
		else if ($urandom_range(0, 39) == 0)
			n_boxes = $urandom_range(MAX_BOXES - 8, MAX_BOXES + 4);
		else
			n_boxes = $urandom_range(1, 10);

		for (k = 0; k < n_boxes; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				// wild box: every bit of every field free
				cx = $urandom;
				cy = $urandom;
				hx = 30'($urandom);
				hy = 30'($urandom);
			end else begin
				cx = bx + jitter(39);
				cy = by + jitter(39);
				hx = half_step();
				hy = half_step();
			end
			if ($urandom_range(0, 29) == 0)
				issue(CMD_UNUSED, $urandom, $urandom, 30'($urandom), 30'($urandom),
					$urandom, $urandom);
			issue(CMD_APPEND, cx, cy, hx, hy, $urandom, $urandom);
			if (scene_n < MAX_BOXES) begin
				scene_cx[scene_n] = cx;
				scene_cy[scene_n] = cy;
				scene_n++;
			end
		end

		n_moves = $urandom_range(1, 6);
		for (k = 0; k < n_moves; k++) begin
			if (scene_n == 0 || $urandom_range(0, 9) == 0) begin
				cx = $urandom;
				cy = $urandom;
				hx = 30'($urandom);
				hy = 30'($urandom);
			end else begin
				// land on a stored box so most resolves see real overlaps
				j  = $urandom_range(0, scene_n - 1);
				cx = scene_cx[j] + jitter(24);
				cy = scene_cy[j] + jitter(24);
				hx = half_step();
				hy = half_step();
			end
			issue(CMD_RESOLVE, cx, cy, hx, hy, $urandom, $urandom);
		end
	endtask

	initial begin
		// every input known from time zero
		arst_n   <= 1'b0;
		start    <= 1'b0;
		command  <= CMD_CLEAR;
		center_x <= '0;
		center_y <= '0;
		half_x   <= '0;
		half_y   <= '0;
		vel_x    <= '0;
		vel_y    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// resolve against an empty table echoes the beat; extreme field values
		issue(CMD_RESOLVE, 32'sh7FFF_FFFF, 32'h8000_0000, H_MAX, 30'h0,
			32'h8000_0000, 32'sh7FFF_FFFF);
		// ignored code, all bits high
		issue(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, H_MAX, H_MAX,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// unit box at the origin
		issue(CMD_APPEND, '0, '0, H_ONE, H_ONE, 32'h5555_5555, 32'hAAAA_AAAA);
		// push out along X to the right, then to the left
		issue(CMD_RESOLVE, Q_ONE + Q_HALF, Q_QTR, H_ONE, H_ONE, $urandom, $urandom);
		issue(CMD_RESOLVE, -(Q_ONE + Q_HALF), Q_QTR, H_ONE, H_ONE, $urandom, $urandom);
		// push out along Y downward, then upward
		issue(CMD_RESOLVE, Q_QTR, -(Q_ONE + Q_HALF), H_ONE, H_ONE, $urandom, $urandom);
		issue(CMD_RESOLVE, Q_QTR, Q_ONE + Q_HALF, H_ONE, H_ONE, $urandom, $urandom);
		// equal penetration on both axes goes to Y
		issue(CMD_RESOLVE, Q_ONE, Q_ONE, H_ONE, H_ONE, $urandom, $urandom);
		// edges touching on X, then on Y: no contact
		issue(CMD_RESOLVE, 2 * Q_ONE, '0, H_ONE, H_ONE, $urandom, $urandom);
		issue(CMD_RESOLVE, '0, -2 * Q_ONE, H_ONE, H_ONE, $urandom, $urandom);
		// centers coincide: zero offset pushes toward negative Y
		issue(CMD_RESOLVE, '0, '0, H_ONE, H_ONE, $urandom, $urandom);
		// second box alongside; one resolve hits both in turn
		issue(CMD_APPEND, 2 * Q_ONE, '0, H_ONE, H_ONE, $urandom, $urandom);
		issue(CMD_RESOLVE, Q_ONE, '0, H_ONE, H_ONE, $urandom, $urandom);
		// clear a populated table
		issue(CMD_CLEAR, $urandom, $urandom, 30'($urandom), 30'($urandom),
			$urandom, $urandom);
		// X push past the top of the range saturates
		issue(CMD_APPEND, 32'sh7FFF_FF00, '0, H_WIDE, H_MAX, $urandom, $urandom);
		issue(CMD_RESOLVE, 32'sh7FFF_FFF0, '0, H_WIDE, H_MAX, $urandom, $urandom);
		// X push past the bottom of the range saturates
		issue(CMD_CLEAR, '0, '0, '0, '0, '0, '0);
		issue(CMD_APPEND, 32'h8000_0100, '0, H_WIDE, H_MAX, $urandom, $urandom);
		issue(CMD_RESOLVE, 32'h8000_0010, '0, H_WIDE, H_MAX, $urandom, $urandom);
		// Y push saturating at the top, then at the bottom
		issue(CMD_APPEND, '0, 32'sh7FFF_FF00, H_MAX, H_WIDE, $urandom, $urandom);
		issue(CMD_RESOLVE, '0, 32'sh7FFF_FFF0, H_MAX, H_WIDE, $urandom, $urandom);
		issue(CMD_APPEND, '0, 32'h8000_0100, H_MAX, H_WIDE, $urandom, $urandom);
		issue(CMD_RESOLVE, '0, 32'h8000_0010, H_MAX, H_WIDE, $urandom, $urandom);
		// ignored code, all bits low
		issue(CMD_UNUSED, '0, '0, '0, '0, '0, '0);

		// random part opens with a table filled past capacity
		beats_sent = 0;
		run_scene(1'b1);
		while (beats_sent < RANDOM_BEATS)
			run_scene(1'b0);
		start <= 1'b0;
		// let the checker queue the last beat before reading its count
		@(posedge clk);

		// wait out the last results, then a short tail for stray beats
		drain = 0;
		while (outstanding != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (outstanding != 0)
			$display("%0t: %0d results never arrived", $time, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#150000000;
		$display("FAIL");
		$finish;
	end

endmodule
